// ===== src/mfba_pkg.sv =====
// shared types and constants for the max flow block
// commands, configuration indexes, controller states and field widths
// no dependencies
package mfba_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int CMD_W            = 2;
    localparam int VTX_FIELD_W      = 4;
    localparam int CAP_W            = 31;
    localparam int RES_W            = 32;
    localparam int FLOW_W           = 36;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 5;

    localparam logic [CAP_W-1:0] BOTTLENECK_START = {CAP_W{1'b1}};
    localparam logic [FLOW_W-1:0] FLOW_MAX        = {FLOW_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VERTEX_COUNT = 2'd0,
        CFG_SOURCE       = 2'd1,
        CFG_SINK         = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_COPY,
        ST_BFS_INIT,
        ST_DEQ,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_AUG_STEP,
        ST_AUG_WR1,
        ST_AUG_RD2,
        ST_AUG_WR2,
        ST_FINISH
    } state_t;

    function automatic logic [FLOW_W-1:0] sat_add(input logic [FLOW_W-1:0] a,
                                                  input logic [CAP_W-1:0] b);
        logic [FLOW_W:0] s;
        s = {1'b0, a} + {{(FLOW_W + 1 - CAP_W){1'b0}}, b};
        return s[FLOW_W] ? FLOW_MAX : s[FLOW_W-1:0];
    endfunction

endpackage

// ===== src/mfba_if.sv =====
// valid/ready channel interfaces for request, result and configuration
// depends on mfba_pkg
interface mfba_req_if
    import mfba_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CMD_W-1:0]       cmd;
    logic [VTX_FIELD_W-1:0] row;
    logic [VTX_FIELD_W-1:0] col;
    logic [CAP_W-1:0]       capacity;
    modport source (output valid, cmd, row, col, capacity, input ready);
    modport sink (input valid, cmd, row, col, capacity, output ready);
endinterface

interface mfba_res_if
    import mfba_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FLOW_W-1:0] total_flow;
    modport source (output valid, total_flow, input ready);
    modport sink (input valid, total_flow, output ready);
endinterface

interface mfba_cfg_if
    import mfba_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== src/mfba_ram.sv =====
// simple dual port synchronous ram, one write and one registered read
// used for the capacity store and the residual store; depends on mfba_pkg
module mfba_ram
    import mfba_pkg::*;
#(
    parameter int WIDTH = RES_W,
    parameter int DEPTH = MAX_VERTICES_DEF * MAX_VERTICES_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== src/max_flow_bfs_augment.sv =====
// edmonds-karp max flow over a capacity ram and a residual ram
// write and unknown items are taken in idle; clear then holds off requests while it zeroes every capacity cell
// run: a bad vertex count, source or sink goes straight to the result; else the capacity ram is copied
// into the residual ram, then each search dequeues vertices, scans their entries and augments along the path,
// all set by the single residual ram port; the result loads once the output register is free after the last
// search; reset sweeps the capacity ram; depends on mfba_pkg, mfba_if and mfba_ram
module max_flow_bfs_augment
    import mfba_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    mfba_req_if.sink   request,
    mfba_res_if.source result,
    mfba_cfg_if.sink   cfg
);
    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int CELLS = MAX_VERTICES * MAX_VERTICES;
    localparam int AW    = $clog2(CELLS);
    localparam int NW    = (VW + 1 > CFG_DATA_W) ? VW + 1 : CFG_DATA_W;
    localparam logic [NW-1:0] MV_N   = NW'(MAX_VERTICES);
    localparam logic [AW:0]   CELLS_C = (AW + 1)'(CELLS);
    localparam logic [VW:0]   MV_C   = (VW + 1)'(MAX_VERTICES);

    function automatic logic [AW-1:0] cell_addr(input logic [VW-1:0] r, input logic [VW-1:0] c);
        return AW'(int'(r) * MAX_VERTICES + int'(c));
    endfunction

    state_t state_reg, state_next;

    logic [CFG_DATA_W-1:0]  vcount_reg;
    logic [VTX_FIELD_W-1:0] src_reg;
    logic [VTX_FIELD_W-1:0] dst_reg;

    logic [AW:0]        cnt_reg, cnt_next;
    logic [MAX_VERTICES-1:0] seen_reg, seen_next;
    logic [VW-1:0]      parent_reg [MAX_VERTICES];
    logic [VW-1:0]      qv_reg [MAX_VERTICES];
    logic [CAP_W-1:0]   qa_reg [MAX_VERTICES];
    logic [VW:0]        head_reg, head_next, tail_reg, tail_next;
    logic [VW-1:0]      u_reg, u_next;
    logic [CAP_W-1:0]   amt_reg, amt_next;
    logic [VW:0]        w_reg, w_next;
    logic [CAP_W-1:0]   b_reg, b_next;
    logic [FLOW_W-1:0]  total_reg, total_next;
    logic [VW-1:0]      v_reg, v_next, p_reg, p_next;
    logic [VW:0]        guard_reg, guard_next;
    logic               out_valid_reg, out_valid_next;
    logic [FLOW_W-1:0]  out_data_reg, out_data_next;

    logic               par_we, q_we, q_init;
    logic [VW-1:0]      par_idx, q_idx;
    logic [CAP_W-1:0]   q_amt;

    logic               cap_we;
    logic [AW-1:0]      cap_waddr, cap_raddr;
    logic [CAP_W-1:0]   cap_wdata, cap_rdata;
    logic               res_we;
    logic [AW-1:0]      res_waddr, res_raddr;
    logic [RES_W-1:0]   res_wdata, res_rdata;

    logic [NW-1:0]      n_eff;
    logic [NW-1:0]      src_n, dst_n;
    logic [VW-1:0]      src_v, dst_v;
    logic [VW-1:0]      w_v;
    logic [CAP_W-1:0]   m_val;

    mfba_ram #(.WIDTH(CAP_W), .DEPTH(CELLS)) u_cap_ram (
        .clk     (clk),
        .wr_en   (cap_we),
        .wr_addr (cap_waddr),
        .wr_data (cap_wdata),
        .rd_addr (cap_raddr),
        .rd_data (cap_rdata)
    );

    mfba_ram #(.WIDTH(RES_W), .DEPTH(CELLS)) u_res_ram (
        .clk     (clk),
        .wr_en   (res_we),
        .wr_addr (res_waddr),
        .wr_data (res_wdata),
        .rd_addr (res_raddr),
        .rd_data (res_rdata)
    );

    assign n_eff = (NW'(vcount_reg) > MV_N) ? MV_N : NW'(vcount_reg);
    assign src_n = NW'(src_reg);
    assign dst_n = NW'(dst_reg);
    assign src_v = VW'(src_reg);
    assign dst_v = VW'(dst_reg);
    assign w_v   = w_reg[VW-1:0];
    assign m_val = (res_rdata < {1'b0, amt_reg}) ? res_rdata[CAP_W-1:0] : amt_reg;

    assign request.ready     = (state_reg == ST_IDLE);
    assign cfg.ready         = 1'b1;
    assign result.valid      = out_valid_reg;
    assign result.total_flow = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= CFG_DATA_W'(16);
            src_reg    <= '0;
            dst_reg    <= VTX_FIELD_W'(15);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_VERTEX_COUNT: vcount_reg <= cfg.data;
                CFG_SOURCE:       src_reg    <= cfg.data[VTX_FIELD_W-1:0];
                CFG_SINK:         dst_reg    <= cfg.data[VTX_FIELD_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            total_reg     <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seen_reg     <= seen_next;
        head_reg     <= head_next;
        tail_reg     <= tail_next;
        u_reg        <= u_next;
        amt_reg      <= amt_next;
        w_reg        <= w_next;
        b_reg        <= b_next;
        v_reg        <= v_next;
        p_reg        <= p_next;
        guard_reg    <= guard_next;
        out_data_reg <= out_data_next;
        if (par_we)
        begin
            parent_reg[par_idx] <= u_reg;
        end
        if (q_we)
        begin
            qv_reg[q_idx] <= q_init ? src_v : w_v;
            qa_reg[q_idx] <= q_amt;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        seen_next      = seen_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        u_next         = u_reg;
        amt_next       = amt_reg;
        w_next         = w_reg;
        b_next         = b_reg;
        total_next     = total_reg;
        v_next         = v_reg;
        p_next         = p_reg;
        guard_next     = guard_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        par_we         = 1'b0;
        par_idx        = w_v;
        q_we           = 1'b0;
        q_init         = 1'b0;
        q_idx          = tail_reg[VW-1:0];
        q_amt          = m_val;
        cap_we         = 1'b0;
        cap_waddr      = cnt_reg[AW-1:0];
        cap_wdata      = '0;
        cap_raddr      = cnt_reg[AW-1:0];
        res_we         = 1'b0;
        res_waddr      = cell_addr(v_reg, p_reg);
        res_wdata      = res_rdata + RES_W'(b_reg);
        res_raddr      = cell_addr(u_reg, w_v);

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (request.valid)
                begin
                    case (request.cmd)
                        CMD_WRITE:
                        begin
                            if (NW'(request.row) < MV_N && NW'(request.col) < MV_N)
                            begin
                                cap_we    = 1'b1;
                                cap_waddr = cell_addr(VW'(request.row), VW'(request.col));
                                cap_wdata = request.capacity;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        CMD_RUN:
                        begin
                            total_next = '0;
                            cnt_next   = '0;
                            if (n_eff < NW'(2) || src_n >= n_eff || dst_n >= n_eff
                                || src_reg == dst_reg)
                            begin
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                state_next = ST_COPY;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                cap_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CELLS_C - 1'b1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_COPY:
            begin
                res_we    = (cnt_reg != '0);
                res_waddr = AW'(cnt_reg - 1'b1);
                res_wdata = {1'b0, cap_rdata};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CELLS_C)
                begin
                    state_next = ST_BFS_INIT;
                end
            end
            ST_BFS_INIT:
            begin
                seen_next        = '0;
                seen_next[src_v] = 1'b1;
                q_we             = 1'b1;
                q_init           = 1'b1;
                q_idx            = '0;
                q_amt            = BOTTLENECK_START;
                head_next        = '0;
                tail_next        = (VW + 1)'(1);
                state_next       = ST_DEQ;
            end
            ST_DEQ:
            begin
                if (head_reg < tail_reg)
                begin
                    u_next     = qv_reg[head_reg[VW-1:0]];
                    amt_next   = qa_reg[head_reg[VW-1:0]];
                    head_next  = head_reg + 1'b1;
                    w_next     = '0;
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCAN_RD:
            begin
                if (NW'(w_reg) == n_eff)
                begin
                    state_next = ST_DEQ;
                end
                else
                begin
                    state_next = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK:
            begin
                w_next     = w_reg + 1'b1;
                state_next = ST_SCAN_RD;
                if (w_v != u_reg && !seen_reg[w_v] && res_rdata != '0)
                begin
                    seen_next[w_v] = 1'b1;
                    par_we         = 1'b1;
                    if (w_v == dst_v)
                    begin
                        b_next     = m_val;
                        total_next = sat_add(total_reg, m_val);
                        v_next     = dst_v;
                        guard_next = '0;
                        state_next = ST_AUG_STEP;
                    end
                    else if (tail_reg < MV_C)
                    begin
                        q_we      = 1'b1;
                        tail_next = tail_reg + 1'b1;
                    end
                end
            end
            ST_AUG_STEP:
            begin
                if (v_reg != src_v && guard_reg < MV_C)
                begin
                    p_next     = parent_reg[v_reg];
                    res_raddr  = cell_addr(v_reg, parent_reg[v_reg]);
                    state_next = ST_AUG_WR1;
                end
                else
                begin
                    state_next = ST_BFS_INIT;
                end
            end
            ST_AUG_WR1:
            begin
                res_we     = 1'b1;
                state_next = ST_AUG_RD2;
            end
            ST_AUG_RD2:
            begin
                res_raddr  = cell_addr(p_reg, v_reg);
                state_next = ST_AUG_WR2;
            end
            ST_AUG_WR2:
            begin
                res_we     = 1'b1;
                res_waddr  = cell_addr(p_reg, v_reg);
                res_wdata  = res_rdata - RES_W'(b_reg);
                v_next     = p_reg;
                guard_next = guard_reg + 1'b1;
                state_next = ST_AUG_STEP;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = total_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

// ===== bench/max_flow_bfs_augment_tb.sv =====
// testbench for max_flow_bfs_augment: capacity writes, clears and max flow runs
// results are checked against an in-bench edmonds-karp predictor
// depends on mfba_pkg, mfba_if and the block itself
`timescale 1ns / 1ps

module max_flow_bfs_augment_tb;
    import mfba_pkg::*;

    localparam logic [CMD_W-1:0]     CMD_UNKNOWN = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;
    localparam logic [CAP_W-1:0]     CAP_UNLIMITED = {CAP_W{1'b1}};
    localparam int NV = MAX_VERTICES_DEF;
    localparam int SETTLE_CYCLES = 2 * NV * NV + 50;

    logic clk;
    logic rst_n;

    mfba_req_if req ();
    mfba_res_if res ();
    mfba_cfg_if cfg ();

    max_flow_bfs_augment uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req),
        .result  (res),
        .cfg     (cfg)
    );

    logic [CAP_W-1:0]  cap_store [NV*NV];
    logic [4:0]        model_vertices;
    logic [3:0]        model_source;
    logic [3:0]        model_sink;
    logic [FLOW_W-1:0] flow_expected [$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int errors;
    int items_sent;
    int runs_sent;
    int flows_checked;
    int cfg_writes;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #400_000_000;
        $display("timeout at %0t", $time);
        $display("TEST FAILED");
        $finish;
    end

    // edmonds-karp on a copy of the capacity store
    function automatic logic [FLOW_W-1:0] predict_flow();
        int unsigned n, s, d, head, tail, u, w, v, p, g;
        logic [RES_W-1:0] resid [NV*NV];
        bit seenv [NV];
        int unsigned parent [NV];
        int unsigned qv [NV];
        logic [RES_W-1:0] qa [NV];
        logic [RES_W-1:0] b, r, m, amt;
        logic [FLOW_W:0] total;
        bit found;
        n = (model_vertices > NV) ? NV : model_vertices;
        s = model_source;
        d = model_sink;
        if (n < 2 || s >= n || d >= n || s == d)
            return '0;
        for (int i = 0; i < NV*NV; i++)
            resid[i] = {1'b0, cap_store[i]};
        total = '0;
        do
        begin
            b = '0;
            found = 0;
            for (int i = 0; i < NV; i++)
                seenv[i] = 0;
            seenv[s] = 1;
            qv[0] = s;
            qa[0] = {1'b0, BOTTLENECK_START};
            head = 0;
            tail = 1;
            while (head < tail && !found)
            begin
                u = qv[head];
                amt = qa[head];
                head++;
                for (w = 0; w < n && !found; w++)
                begin
                    r = resid[u*NV + w];
                    if (w != u && !seenv[w] && r != 0)
                    begin
                        m = (r < amt) ? r : amt;
                        seenv[w] = 1;
                        parent[w] = u;
                        if (w == d)
                        begin
                            b = m;
                            found = 1;
                        end
                        else if (tail < NV)
                        begin
                            qv[tail] = w;
                            qa[tail] = m;
                            tail++;
                        end
                    end
                end
            end
            if (b != 0)
            begin
                total = total + b;
                if (total > {1'b0, FLOW_MAX})
                    total = {1'b0, FLOW_MAX};
                v = d;
                g = 0;
                while (v != s && g < NV)
                begin
                    p = parent[v] % NV;
                    resid[v*NV + p] = resid[v*NV + p] + b;
                    resid[p*NV + v] = resid[p*NV + v] - b;
                    v = p;
                    g++;
                end
            end
        end
        while (b != 0);
        return total[FLOW_W-1:0];
    endfunction

    task automatic apply_item(input logic [CMD_W-1:0] c, input logic [3:0] rw,
                              input logic [3:0] cl, input logic [CAP_W-1:0] cp);
        case (c)
            CMD_WRITE: cap_store[rw*NV + cl] = cp;
            CMD_CLEAR:
                for (int i = 0; i < NV*NV; i++)
                    cap_store[i] = '0;
            CMD_RUN:
            begin
                flow_expected.push_back(predict_flow());
                runs_sent++;
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input logic [CMD_W-1:0] c, input logic [3:0] rw,
                             input logic [3:0] cl, input logic [CAP_W-1:0] cp);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid    <= 1'b1;
        req.cmd      <= c;
        req.row      <= rw;
        req.col      <= cl;
        req.capacity <= cp;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        apply_item(c, rw, cl, cp);
        items_sent++;
    endtask

    task automatic wait_idle();
        req.valid <= 1'b0;
        @(posedge clk);
        while (flow_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [4:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        case (idx)
            CFG_VERTEX_COUNT: model_vertices = val;
            CFG_SOURCE:       model_source = val[3:0];
            CFG_SINK:         model_sink = val[3:0];
            default: ;
        endcase
        cfg_writes++;
        @(posedge clk);
    endtask

    task automatic set_graph(input logic [4:0] n, input logic [4:0] s, input logic [4:0] d);
        wait_idle();
        write_cfg(CFG_VERTEX_COUNT, n);
        write_cfg(CFG_SOURCE, s);
        write_cfg(CFG_SINK, d);
    endtask

    function automatic logic [CAP_W-1:0] pick_capacity();
        int k;
        k = $urandom_range(0, 9);
        if (k < 5)
            return CAP_W'($urandom_range(1, 20));
        else if (k == 5)
            return '0;
        else if (k == 6)
            return CAP_UNLIMITED;
        else
            return CAP_W'($urandom);
    endfunction

    task automatic test_directed();
        set_graph(5'd4, 5'd0, 5'd3);
        send_item(CMD_WRITE, 4'd0, 4'd1, CAP_UNLIMITED);
        send_item(CMD_WRITE, 4'd1, 4'd3, CAP_UNLIMITED);
        send_item(CMD_WRITE, 4'd0, 4'd2, 31'd5);
        send_item(CMD_WRITE, 4'd2, 4'd3, 31'd7);
        send_item(CMD_WRITE, 4'd1, 4'd1, 31'd9);
        send_item(CMD_WRITE, 4'd15, 4'd15, CAP_UNLIMITED);
        send_item(CMD_UNKNOWN, 4'd15, 4'd0, CAP_UNLIMITED);
        send_item(CMD_RUN, 4'd0, 4'd0, '0);
        send_item(CMD_WRITE, 4'd0, 4'd1, '0);
        send_item(CMD_RUN, 4'd15, 4'd15, CAP_UNLIMITED);
        send_item(CMD_CLEAR, 4'd0, 4'd0, '0);
        send_item(CMD_RUN, 4'd0, 4'd0, '0);
        set_graph(5'd16, 5'd0, 5'd15);
        send_item(CMD_WRITE, 4'd0, 4'd15, CAP_UNLIMITED);
        send_item(CMD_WRITE, 4'd0, 4'd7, CAP_UNLIMITED);
        send_item(CMD_WRITE, 4'd7, 4'd15, CAP_UNLIMITED);
        send_item(CMD_RUN, 4'd0, 4'd0, '0);
        set_graph(5'd31, 5'd15, 5'd15);
        send_item(CMD_RUN, 4'd0, 4'd0, '0);
        set_graph(5'd0, 5'd0, 5'd1);
        send_item(CMD_RUN, 4'd0, 4'd0, '0);
        set_graph(5'd1, 5'd0, 5'd0);
        send_item(CMD_RUN, 4'd0, 4'd0, '0);
        set_graph(5'd3, 5'd0, 5'd7);
        send_item(CMD_RUN, 4'd0, 4'd0, '0);
        wait_idle();
        write_cfg(CFG_UNUSED, 5'd31);
        set_graph(5'd17, 5'd15, 5'd0);
        send_item(CMD_WRITE, 4'd15, 4'd0, 31'd1);
        send_item(CMD_RUN, 4'd0, 4'd0, '0);
    endtask

    task automatic random_graph_set(input int budget);
        int used, k, edges;
        logic [4:0] n, s, d;
        logic [3:0] rw, cl;
        used = 0;
        while (used < budget)
        begin
            k = $urandom_range(0, 19);
            if (k == 0)
                n = 5'd16;
            else if (k == 1)
                n = 5'($urandom_range(17, 31));
            else if (k == 2)
                n = 5'($urandom_range(0, 1));
            else
                n = 5'($urandom_range(2, 7));
            if ($urandom_range(0, 9) == 0)
            begin
                s = 5'($urandom);
                d = 5'($urandom);
            end
            else
            begin
                s = 5'($urandom_range(0, (n > 16 ? 16 : (n < 2 ? 2 : n)) - 1));
                d = 5'($urandom_range(0, (n > 16 ? 16 : (n < 2 ? 2 : n)) - 1));
            end
            set_graph(n, s, d);
            repeat ($urandom_range(2, 4))
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    send_item(CMD_CLEAR, 4'($urandom), 4'($urandom), CAP_W'($urandom));
                    used++;
                end
                edges = $urandom_range(3, (n == 16) ? 40 : 14);
                repeat (edges)
                begin
                    k = $urandom_range(0, 19);
                    if (k == 0)
                        send_item(CMD_UNKNOWN, 4'($urandom), 4'($urandom),
                                  CAP_W'($urandom));
                    else
                    begin
                        if (k < 3 || n < 2)
                        begin
                            rw = 4'($urandom);
                            cl = 4'($urandom);
                        end
                        else
                        begin
                            rw = 4'($urandom_range(0, (n > 16 ? 16 : n) - 1));
                            cl = 4'($urandom_range(0, (n > 16 ? 16 : n) - 1));
                        end
                        send_item(CMD_WRITE, rw, cl, pick_capacity());
                    end
                    used++;
                end
                send_item(CMD_RUN, 4'($urandom), 4'($urandom), CAP_W'($urandom));
                used++;
            end
        end
    endtask

    task automatic test_random_phases();
        send_idle_pct = 31;
        recv_idle_pct = 64;
        random_graph_set(480);
        send_idle_pct = 64;
        recv_idle_pct = 31;
        random_graph_set(480);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_graph_set(480);
    endtask

    task automatic test_backpressure();
        set_graph(5'd3, 5'd0, 5'd2);
        send_idle_pct = 0;
        hold_left = 4000;
        repeat (20)
        begin
            send_item(CMD_WRITE, 4'($urandom_range(0, 2)), 4'($urandom_range(0, 2)),
                      pick_capacity());
            send_item(CMD_RUN, 4'd0, 4'd0, '0);
        end
        wait_idle();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
        begin
            if (flow_expected.size() == 0)
            begin
                $display("%0t: unexpected result total_flow=%0d", $time, res.total_flow);
                errors++;
            end
            else
            begin
                if (res.total_flow !== flow_expected[0])
                begin
                    $display("%0t: total_flow mismatch expected=%0d actual=%0d",
                             $time, flow_expected[0], res.total_flow);
                    errors++;
                end
                flow_expected.pop_front();
                flows_checked++;
            end
        end
        if (hold_left > 0)
        begin
            res.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            res.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial
    begin
        int guard;
        errors = 0;
        items_sent = 0;
        runs_sent = 0;
        flows_checked = 0;
        cfg_writes = 0;
        hold_left = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        model_vertices = 5'd16;
        model_source = 4'd0;
        model_sink = 4'd15;
        for (int i = 0; i < NV*NV; i++)
            cap_store[i] = '0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.cmd = CMD_WRITE;
        req.row = '0;
        req.col = '0;
        req.capacity = '0;
        cfg.valid = 1'b0;
        cfg.index = CFG_VERTEX_COUNT;
        cfg.data = '0;
        res.ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_phases();
        test_backpressure();
        req.valid <= 1'b0;
        guard = 0;
        while (flow_expected.size() != 0 && guard < 5_000_000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (flow_expected.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, flow_expected.size());
            errors++;
        end
        $display("covered %0d items (%0d runs, %0d flows checked), %0d config writes",
                 items_sent, runs_sent, flows_checked, cfg_writes);
        $display("idling phases, a long result hold-off and directed corner graphs; errors %0d",
                 errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
